>>> sv/mmtd_pkg.sv
// mmtd_pkg: types, codes and constants shared by the mirror metadata deframer.
// It has no dependencies. The parser, the result queue and the top level import it.
package mmtd_pkg;

  // item type codes
  localparam logic [7:0] TYPE_HOST     = 8'd1;
  localparam logic [7:0] TYPE_FLAGS    = 8'd2;
  localparam logic [7:0] TYPE_SRC_NAME = 8'd3;
  localparam logic [7:0] TYPE_DST_NAME = 8'd4;
  localparam logic [7:0] TYPE_END      = 8'd255;

  // direction bit within the flags word
  localparam logic [31:0] INGRESS_BIT = 32'h4000_0000;

  // default depth of the result queue
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_VALUE,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    K_HOST  = 3'd0,
    K_SRC   = 3'd1,
    K_DST   = 3'd2,
    K_HDR   = 3'd3,
    K_PAY   = 3'd4,
    K_TRUNC = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    IP_NONE = 2'd0,
    IP_V4   = 2'd1,
    IP_V6   = 2'd2
  } ipk_t;

  // one result beat
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  idx;
    logic [1:0]  ipk;
    logic        ing;
    logic [31:0] act;
    logic        last;
  } res_t;

  // up to two results produced by one input beat, first in d0
  typedef struct packed {
    logic [1:0] n;
    res_t       d0;
    res_t       d1;
  } push_t;

endpackage

>>> sv/mmtd_parser.sv
// mmtd_parser: TLV header state and result formation for one input beat.
// Depends on mmtd_pkg; feeds mmtd_outq through a push_t bundle.
module mmtd_parser
  import mmtd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] pkt_byte,
  input  logic       pkt_end,
  output push_t      push
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  tkind_r, tkind_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [1:0]  host_r, host_nxt;
  logic        ing_r, ing_nxt;
  logic [31:0] flag_r, flag_nxt;

  logic        val_last;
  logic        done;
  logic [7:0]  pos_v;
  logic [31:0] flag_acc;
  logic [1:0]  host_fin;
  logic        byte_vld;
  logic        tail_vld;
  res_t        res_a;
  res_t        res_b;

  // shared decode: item completion, flags accumulation, host kind
  always_comb begin
    val_last = ((phase_r == PH_LEN) && (pkt_byte == 8'd0)) ||
               ((phase_r == PH_VALUE) && (left_r == 8'd1));
    done     = val_last && (tkind_r == TYPE_END);
    pos_v    = (phase_r == PH_VALUE) ? pos_r + 8'd1 : 8'd0;
    flag_acc = flag_r;
    if (tkind_r == TYPE_FLAGS) begin
      if (phase_r == PH_LEN) begin
        flag_acc = '0;
      end else if ((phase_r == PH_VALUE) && (pos_r[7:2] == 6'd0)) begin
        case (pos_r[1:0])
          2'd0:    flag_acc = flag_r | {pkt_byte, 24'd0};
          2'd1:    flag_acc = flag_r | {8'd0, pkt_byte, 16'd0};
          2'd2:    flag_acc = flag_r | {16'd0, pkt_byte, 8'd0};
          default: flag_acc = flag_r | {24'd0, pkt_byte};
        endcase
      end
    end
    host_fin = host_r;
    if (pos_v == 8'd4) begin
      host_fin = IP_V4;
    end else if (pos_v == 8'd16) begin
      host_fin = IP_V6;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    tkind_nxt = tkind_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    host_nxt  = host_r;
    ing_nxt   = ing_r;
    flag_nxt  = flag_r;
    if (fire) begin
      case (phase_r)
        PH_TYPE: begin
          tkind_nxt = pkt_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          left_nxt  = pkt_byte;
          pos_nxt   = 8'd0;
          flag_nxt  = flag_acc;
          phase_nxt = PH_VALUE;
        end
        PH_VALUE: begin
          left_nxt = left_r - 8'd1;
          pos_nxt  = pos_v;
          flag_nxt = flag_acc;
        end
        default: ;
      endcase
      // item complete
      if (val_last) begin
        if (done) begin
          phase_nxt = PH_PAYLOAD;
        end else begin
          phase_nxt = PH_TYPE;
          if (tkind_r == TYPE_HOST) begin
            host_nxt = host_fin;
          end else if (tkind_r == TYPE_FLAGS) begin
            ing_nxt  = flag_acc[30];
            flag_nxt = flag_acc & ~INGRESS_BIT;
          end
        end
      end
      // any packet end returns to a clean state
      if (pkt_end) begin
        phase_nxt = PH_TYPE;
        tkind_nxt = '0;
        left_nxt  = '0;
        pos_nxt   = '0;
        host_nxt  = '0;
        ing_nxt   = 1'b0;
        flag_nxt  = '0;
      end
    end
  end

  // result formation: byte result first, then header or truncation
  always_comb begin
    res_a    = '0;
    res_b    = '0;
    byte_vld = 1'b0;
    tail_vld = 1'b0;
    if (phase_r == PH_PAYLOAD) begin
      byte_vld   = 1'b1;
      res_a.kind = K_PAY;
      res_a.data = pkt_byte;
      res_a.last = pkt_end;
    end else if (phase_r == PH_VALUE) begin
      res_a.data = pkt_byte;
      res_a.idx  = pos_r;
      if (tkind_r == TYPE_HOST) begin
        byte_vld   = 1'b1;
        res_a.kind = K_HOST;
      end else if (tkind_r == TYPE_SRC_NAME) begin
        byte_vld   = 1'b1;
        res_a.kind = K_SRC;
      end else if (tkind_r == TYPE_DST_NAME) begin
        byte_vld   = 1'b1;
        res_a.kind = K_DST;
      end
    end
    if (done) begin
      tail_vld   = 1'b1;
      res_b.kind = K_HDR;
      res_b.ipk  = host_r;
      res_b.ing  = ing_r;
      res_b.act  = flag_r;
      res_b.last = pkt_end;
    end else if (pkt_end && (phase_r != PH_PAYLOAD)) begin
      tail_vld   = 1'b1;
      res_b.kind = K_TRUNC;
      res_b.last = 1'b1;
    end
    push.d0 = byte_vld ? res_a : res_b;
    push.d1 = res_b;
    if (!fire) begin
      push.n = 2'd0;
    end else begin
      push.n = {1'b0, byte_vld} + {1'b0, tail_vld};
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      tkind_r <= '0;
      left_r  <= '0;
      pos_r   <= '0;
      host_r  <= '0;
      ing_r   <= 1'b0;
      flag_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      tkind_r <= tkind_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      host_r  <= host_nxt;
      ing_r   <= ing_nxt;
      flag_r  <= flag_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a packet end always leaves the parser waiting for a type byte
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && pkt_end |=> (phase_r == PH_TYPE) && (flag_r == '0))
    else $error("parser state not cleared after packet end");

  // the stored flags word never keeps the direction bit once an item is done
  a_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TYPE || phase_r == PH_PAYLOAD) |-> !flag_r[30])
    else $error("direction bit left in flags word");

  // a second result is only ever a header or truncation
  a_two_tail: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> (push.d1.kind == K_HDR || push.d1.kind == K_TRUNC))
    else $error("bad second result");
`endif

endmodule

>>> sv/mmtd_outq.sv
// mmtd_outq: shifting result queue, takes up to two results a cycle, gives one.
// Depends on mmtd_pkg; head entry drives the result channel.
module mmtd_outq
  import mmtd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  ready,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  head
);

  localparam int CW = $clog2(DEPTH + 1);

  res_t          ent_r [DEPTH];
  res_t          ent_nxt [DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] base;
  logic          pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign base      = cnt_r - CW'(pop);
  assign ready     = (cnt_r <= CW'(DEPTH - 2));
  assign head      = ent_r[0];
  assign cnt_nxt   = cnt_r - CW'(pop) + CW'(push.n);

  // shift on pop, then place new results behind the survivors
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      ent_nxt[i] = pop ? ent_r[i+1] : ent_r[i];
    end
    ent_nxt[DEPTH-1] = ent_r[DEPTH-1];
    for (int i = 0; i < DEPTH; i++) begin
      if ((push.n != 2'd0) && (base == CW'(i))) begin
        ent_nxt[i] = push.d0;
      end
      if ((push.n == 2'd2) && ((base + CW'(1)) == CW'(i))) begin
        ent_nxt[i] = push.d1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("result queue overflow");

  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> cnt_r <= CW'(DEPTH - 2))
    else $error("push without room for two results");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (push.n == 2'd0) |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("queue count wrong after pop");
`endif

endmodule

>>> sv/mirror_metadata_tlv_deframer_unit.sv
// Mirror metadata TLV deframer: one packet byte a beat in, tagged results out.
// Results are registered in the result queue before they are offered.
// Throughput: one byte per cycle; a byte yields at most two results, both held in a
//   queue of Q_DEPTH entries (4 by default), and input stalls only while it holds Q_DEPTH-1 or more.
// Reset: synchronous active-low rst_n clears parser state and empties the queue.
// Depends on mmtd_pkg, mmtd_parser and mmtd_outq.
module mirror_metadata_tlv_deframer_unit
  import mmtd_pkg::*;
#(
  parameter int Q_DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_pkt_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [7:0]  out_value_index,
  output logic [1:0]  out_ip_kind,
  output logic        out_ingress,
  output logic [31:0] out_action_bits,
  output logic        out_last
);

  push_t push;
  res_t  head;
  logic  fire;

  assign fire = in_valid && in_ready;

  mmtd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .pkt_byte (in_pkt_byte),
    .pkt_end  (in_pkt_end),
    .push     (push)
  );

  mmtd_outq #(
    .DEPTH (Q_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind        = head.kind;
  assign out_byte        = head.data;
  assign out_value_index = head.idx;
  assign out_ip_kind     = head.ipk;
  assign out_ingress     = head.ing;
  assign out_action_bits = head.act;
  assign out_last        = head.last;

endmodule
